// ===== src/assert_macros.svh =====
// Assertion helpers for the execute block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/rvx_pkg.sv =====
package rvx_pkg;
    localparam int DMEM_WORDS = 16384;
    localparam int IMEM_WORDS = 1024;
    localparam int DMEM_AW = $clog2(DMEM_WORDS);
    localparam int IMEM_AW = $clog2(IMEM_WORDS);

    localparam logic [6:0] OPC_R     = 7'b0110011;
    localparam logic [6:0] OPC_I     = 7'b0010011;
    localparam logic [6:0] OPC_S     = 7'b0100011;
    localparam logic [6:0] OPC_L     = 7'b0000011;
    localparam logic [6:0] OPC_B     = 7'b1100011;
    localparam logic [6:0] OPC_LUI   = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC = 7'b0010111;
    localparam logic [6:0] OPC_JAL   = 7'b1101111;
    localparam logic [6:0] OPC_JALR  = 7'b1100111;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [31:0] WIN_BASE = 32'h1000_0000;

    // queued item between front and back
    typedef struct packed {
        logic        op;
        logic [31:0] instr;
        logic [31:0] console_value;
        logic [13:0] preload_index;
        logic [31:0] preload_value;
    } item_t;

    localparam logic [1:0] Q_DEPTH = 2'd2;
endpackage

// ===== src/rvx_ram.sv =====
module rvx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/rvx_front.sv =====
// Two-entry input queue: takes items while the back end is busy.
module rvx_front import rvx_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    output logic  q_valid,
    output item_t q_item,
    input  logic  q_pop
);
    item_t      buf_reg [2];
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign in_stall = (cnt_reg == Q_DEPTH);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg ^ q_pop;
        wr_next  = wr_reg ^ push;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= in_item;
        end
    end
endmodule

// ===== src/rvx_back.sv =====
// Execute engine: read cycle then execute cycle, one result register.
module rvx_back import rvx_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  next_pc,
    output logic        reg_write_valid,
    output logic [4:0]  reg_index,
    output logic [31:0] reg_value,
    output logic        console_read,
    output logic        console_out_valid,
    output logic [7:0]  console_char
);
    typedef enum logic [1:0] {
        S_READ = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    item_t  it_reg;
    logic [31:0] rf_reg [32];
    logic [31:0] r1_reg, r2_reg;
    logic [31:0] dm_rdata;
    logic [IMEM_AW-1:0] pc_reg;
    logic [DMEM_AW-1:0] sweep_reg;
    logic clr_reg;
    logic ov_reg;

    // execute decode
    logic [6:0]  opc, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, pcb, val, tgt, ea, a_b, sum, ld_ea;
    logic [31:0] sh_b;
    logic        wr, jump, take, cons_rd, cons_out, dm_we, fire, alt, ok;
    logic [IMEM_AW-1:0] nxt, tw;
    logic [DMEM_AW-1:0] dm_waddr, dm_raddr;
    logic [31:0] dm_wdata;
    logic [31:0] st_off;
    logic [31:0] rd_off;

    assign fire  = (state_reg == S_EXEC) && (!ov_reg || !out_stall);
    assign q_pop = fire;
    assign out_valid = ov_reg;

    // load address computed from registers read in the first cycle
    assign ld_ea = r1_reg + imm_i;

    always_comb
    begin
        opc   = it_reg.instr[6:0];
        rd    = it_reg.instr[11:7];
        f3    = it_reg.instr[14:12];
        f7    = it_reg.instr[31:25];
        imm_i = {{20{it_reg.instr[31]}}, it_reg.instr[31:20]};
        imm_s = {{20{it_reg.instr[31]}}, it_reg.instr[31:25], it_reg.instr[11:7]};
        imm_b = {{19{it_reg.instr[31]}}, it_reg.instr[31], it_reg.instr[7],
                 it_reg.instr[30:25], it_reg.instr[11:8], 1'b0};
        imm_j = {{11{it_reg.instr[31]}}, it_reg.instr[31], it_reg.instr[19:12],
                 it_reg.instr[20], it_reg.instr[30:21], 1'b0};
        pcb   = {{(30-IMEM_AW){1'b0}}, pc_reg, 2'b00};
        nxt   = pc_reg + 1'b1;
        alt   = (f7 == F7_ALT);
        a_b   = (opc == OPC_R) ? r2_reg : imm_i;
        sh_b  = {27'd0, a_b[4:0]};
        wr = 1'b0; jump = 1'b0; take = 1'b0; cons_rd = 1'b0; cons_out = 1'b0;
        dm_we = 1'b0; val = 32'd0; tgt = 32'd0; ok = 1'b1; ea = 32'd0;
        sum = 32'd0;
        // ALU result
        case (f3)
            3'd0: val = (alt && opc == OPC_R) ? r1_reg - a_b : r1_reg + a_b;
            3'd1: val = r1_reg << sh_b[4:0];
            3'd2: val = ($signed(r1_reg) < $signed(a_b)) ? 32'd1 : 32'd0;
            3'd4: val = r1_reg ^ a_b;
            3'd5: val = alt ? 32'($signed(r1_reg) >>> sh_b[4:0]) : r1_reg >> sh_b[4:0];
            3'd6: val = r1_reg | a_b;
            3'd7: val = r1_reg & a_b;
            default: ok = 1'b0;
        endcase
        case (opc)
            OPC_R:
            begin
                if ((f7 == 7'd0 || alt) && ok && (!alt || f3 == 3'd0 || f3 == 3'd5))
                begin
                    wr = 1'b1;
                end
            end
            OPC_I:
            begin
                if (f3 == 3'd1)
                begin
                    wr = 1'b1;
                end
                else if (f3 == 3'd5)
                begin
                    wr = (f7 == 7'd0) || alt;
                end
                else
                begin
                    wr = ok;
                end
            end
            OPC_L:
            begin
                if (f3 == 3'd2)
                begin
                    wr = 1'b1;
                    ea = ld_ea;
                    if ((ea - WIN_BASE) < WIN_BASE)
                    begin
                        val = dm_rdata;
                    end
                    else
                    begin
                        val = it_reg.console_value;
                        cons_rd = 1'b1;
                    end
                end
            end
            OPC_S:
            begin
                ea = r1_reg + imm_s;
                if ((ea - WIN_BASE) < WIN_BASE)
                begin
                    dm_we = 1'b1;
                end
                else
                begin
                    cons_out = 1'b1;
                end
            end
            OPC_B:
            begin
                case (f3)
                    3'd0: take = (r1_reg == r2_reg);
                    3'd1: take = (r1_reg != r2_reg);
                    3'd4: take = $signed(r1_reg) < $signed(r2_reg);
                    3'd5: take = !($signed(r1_reg) < $signed(r2_reg));
                    default: take = 1'b0;
                endcase
                jump = take;
                tgt  = pcb + imm_b;
            end
            OPC_LUI:
            begin
                val = {it_reg.instr[31:12], 12'd0};
                wr  = 1'b1;
            end
            OPC_AUIPC:
            begin
                sum = pcb + {it_reg.instr[31:12], 12'd0};
                val = sum;
                wr  = 1'b1;
            end
            OPC_JAL:
            begin
                // link is the byte address after pc, not wrapped to the pc range
                val  = pcb + 32'd4;
                wr   = 1'b1;
                jump = 1'b1;
                tgt  = pcb + imm_j;
            end
            OPC_JALR:
            begin
                if (f3 == 3'd0)
                begin
                    val  = pcb + 32'd4;
                    wr   = 1'b1;
                    jump = 1'b1;
                    tgt  = r1_reg + imm_i;
                end
            end
            default: ;
        endcase
        tw = tgt[IMEM_AW+1:2];
        if (jump && tw != pc_reg)
        begin
            nxt = tw;
        end
        if (!(wr && rd != 5'd0))
        begin
            wr  = 1'b0;
            val = 32'd0;
        end
    end

    // memory ports: clearing sweep, preload, store
    always_comb
    begin
        st_off   = ea - WIN_BASE;
        dm_wdata = r2_reg;
        dm_waddr = st_off[DMEM_AW+1:2];
        if (clr_reg)
        begin
            dm_waddr = sweep_reg;
            dm_wdata = '1;
        end
        else if (it_reg.op)
        begin
            dm_waddr = it_reg.preload_index[DMEM_AW-1:0];
            dm_wdata = it_reg.preload_value;
        end
    end

    assign rd_off   = (rf_reg[q_item.instr[19:15]]
                      + {{20{q_item.instr[31]}}, q_item.instr[31:20]}) - WIN_BASE;
    assign dm_raddr = rd_off[DMEM_AW+1:2];

    rvx_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
        .clk   (clk),
        .we    (clr_reg || (fire && (it_reg.op || dm_we))),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .raddr (dm_raddr),
        .rdata (dm_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_READ: if (q_valid && !clr_reg) state_next = S_EXEC;
            S_EXEC: if (fire) state_next = S_READ;
            default: state_next = S_READ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_READ;
            pc_reg    <= '0;
            ov_reg    <= 1'b0;
            clr_reg   <= 1'b1;
            sweep_reg <= '0;
            for (int i = 0; i < 32; i++) rf_reg[i] <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_reg)
            begin
                sweep_reg <= sweep_reg + 1'b1;
                if (sweep_reg == DMEM_AW'(DMEM_WORDS - 1)) clr_reg <= 1'b0;
            end
            if (fire)
            begin
                ov_reg <= 1'b1;
                if (!it_reg.op)
                begin
                    pc_reg <= nxt;
                    if (wr) rf_reg[rd] <= val;
                end
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            it_reg <= q_item;
            r1_reg <= rf_reg[q_item.instr[19:15]];
            r2_reg <= rf_reg[q_item.instr[24:20]];
        end
        if (fire)
        begin
            next_pc           <= it_reg.op ? pc_reg : nxt;
            reg_write_valid   <= !it_reg.op && wr;
            reg_index         <= (!it_reg.op && wr) ? rd : 5'd0;
            reg_value         <= it_reg.op ? 32'd0 : val;
            console_read      <= !it_reg.op && cons_rd;
            console_out_valid <= !it_reg.op && cons_out;
            console_char      <= (!it_reg.op && cons_out) ? r2_reg[7:0] : 8'd0;
        end
    end
endmodule

// ===== src/rv32i_subset_execute.sv =====
// RV32I subset execute block.
// Input channel (in_valid/in_stall): op selects execute or data preload;
// instr is the word fetched at the current pc, console_value feeds loads
// outside the data window, preload_index/preload_value fill data memory.
// Output channel (out_valid/out_stall): one result per item carrying the
// next pc, any register write and console activity.
// A two-entry queue decouples the input from the execute engine.
// In the engine each item goes through a register-file/data-memory read
// state (the data-memory read port is registered), then an execute state
// that writes the result register and waits while a stalled result is
// held. The engine takes the next item only after the current one executes.
// After reset the data memory is swept to all ones, one word a cycle over
// all 16384 words, during which items queue but are not executed.
// Registers and pc reset to zero. When the receiver stalls the result
// holds, and the queue keeps taking items until it is full.
`include "assert_macros.svh"
module rv32i_subset_execute import rvx_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] instr,
    input  logic signed [31:0] console_value,
    input  logic [13:0] preload_index,
    input  logic [31:0] preload_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  next_pc,
    output logic        reg_write_valid,
    output logic [4:0]  reg_index,
    output logic [31:0] reg_value,
    output logic        console_read,
    output logic        console_out_valid,
    output logic [7:0]  console_char
);
    item_t in_item, q_item;
    logic  q_valid, q_pop;

    assign in_item = '{op: op, instr: instr, console_value: console_value,
                       preload_index: preload_index, preload_value: preload_value};

    rvx_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    rvx_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .out_valid(out_valid), .out_stall(out_stall), .next_pc(next_pc),
        .reg_write_valid(reg_write_valid), .reg_index(reg_index),
        .reg_value(reg_value), .console_read(console_read),
        .console_out_valid(console_out_valid), .console_char(console_char)
    );

    `ASSERT_IMPL(a_pop_needs_item, q_pop, q_valid)
    `ASSERT_NEXT(a_pop_gives_result, q_pop, out_valid)
    `ASSERT_IMPL(a_write_has_index, out_valid && reg_write_valid, reg_index != 5'd0)
endmodule
